>>> sv/iet_pkg.sv
// ----------------------------------------------------------------------------
// iet_pkg
// shared types and fixed constants of the incremental entropy tracker
// ----------------------------------------------------------------------------
package iet_pkg;

    localparam int ENT_W     = 20;  // entropy output width
    localparam int CHUNK_W   = 16;  // count slice fed to the multiplier per cycle
    localparam int MANT_W    = 31;  // log mantissa, Q1.30
    localparam int MANT_FRAC = 30;
    localparam int MUL_W     = 32;  // shared multiplier operand width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOG_LOAD,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_MUL,
        ST_DIV_CHK,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

>>> sv/incremental_entropy_tracker.sv
// ----------------------------------------------------------------------------
// incremental_entropy_tracker
// running shannon entropy of a weighted symbol stream, one word at a time
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  input   | in        | i_valid / o_stall | i_symbol, i_weight, i_new_set
//  output  | out       | o_valid / i_stall | o_entropy, o_overflow
//
//  one word at a time; o_stall is high from acceptance until the result is
//  loaded into the output register. a word's run time is set by the four log
//  evaluations on the shared 32x32 multiplier and the bit-serial divider; the
//  first word of a set and a refused word skip both.
//  reset clears the control state, totals and the per-symbol valid bits.
//  a result waiting under i_stall holds the next result back, not the input.
// ----------------------------------------------------------------------------
module incremental_entropy_tracker #(
    parameter int SYMBOLS     = 256,
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_symbol,
    input  logic [15:0]              i_weight,
    input  logic                     i_new_set,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [iet_pkg::ENT_W-1:0] o_entropy,
    output logic                     o_overflow
);
    import iet_pkg::*;

    localparam int CW     = COUNT_WIDTH;
    localparam int IW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int XW     = (CW > MANT_W) ? CW : MANT_W;
    localparam int NSTEPS = $clog2(XW);
    localparam int EW     = NSTEPS;
    localparam int NSW    = NSTEPS + 1;
    localparam int LW     = EW + FRAC_BITS;
    localparam int QW     = LW + 1;
    localparam int AW     = LW + CW + 1;
    localparam int CHUNKS = (CW + CHUNK_W - 1) / CHUNK_W;
    localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int SW     = $clog2(QW + 1);
    localparam int HW     = (LW > ENT_W) ? LW : ENT_W;
    localparam longint LIM_RAW = 64'(8) << FRAC_BITS;
    localparam longint ENT_MAX = (64'(1) << ENT_W) - 1;
    localparam longint LIM     = (LIM_RAW > ENT_MAX) ? ENT_MAX : LIM_RAW;

    // state
    t_state                r_state, n_state;
    logic [SYMBOLS-1:0]    r_valid, n_valid;
    logic [CW-1:0]         r_total, n_total;
    logic [ENT_W-1:0]      r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    logic [ENT_W-1:0]      r_out_ent, n_out_ent;
    logic                  r_out_ovf, n_out_ovf;

    // per-word working registers
    logic [IW-1:0]         r_idx, n_idx;
    logic [15:0]           r_w, n_w;
    logic [CW-1:0]         r_rd;
    logic [CW-1:0]         r_f, n_f;
    logic [CW-1:0]         r_n, n_n;
    logic [CW-1:0]         r_fw, n_fw;
    logic                  r_ovf, n_ovf;
    logic [ENT_W-1:0]      r_h, n_h;
    logic [1:0]            r_lsel, n_lsel;
    logic [SW-1:0]         r_step, n_step;
    logic [XW-1:0]         r_x, n_x;
    logic                  r_xzero, n_xzero;
    logic [EW-1:0]         r_exp, n_exp;
    logic [MANT_W-1:0]     r_m, n_m;
    logic [FRAC_BITS-1:0]  r_frac, n_frac;
    logic [LW-1:0]         r_lc, n_lc, r_ln, n_ln, r_lf, n_lf, r_lfw, n_lfw;
    logic [1:0]            r_term, n_term;
    logic [CKW-1:0]        r_chunk, n_chunk;
    logic [AW-1:0]         r_acc, n_acc;
    logic [CW-1:0]         r_rem, n_rem;
    logic [QW-1:0]         r_q, n_q;

    logic [CW-1:0]         mem [SYMBOLS];

    // combinational helpers
    logic                  in_acc, fin_go, mem_we;
    logic [IW-1:0]         in_idx;
    logic [16:0]           mod_r;
    logic [CW-1:0]         f_cur;
    logic [CW:0]           sum_n;
    logic [CW-1:0]         log_x;
    logic [NSW-1:0]        sh;
    logic [XW-1:0]         hi_mask, x_sh;
    logic                  top_zero;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic [MUL_W-1:0]      sq_t;
    logic [LW-1:0]         log_val;
    logic [HW-1:0]         lc_x, last_x, d_x;
    logic [LW-1:0]         mac_log;
    logic [CW-1:0]         mac_cnt;
    logic [CHUNKS*CHUNK_W-1:0] cnt_pad;
    logic [CHUNK_W-1:0]    chunk;
    logic [AW-1:0]         mac_term;
    logic [CW-1:0]         acc_hi;
    logic [CW:0]           rem2;
    logic                  q_bit;
    logic [LW-1:0]         h_raw;
    logic [HW-1:0]         h_x;
    logic                  norm_last, sq_last, mul_last, div_last, div_skip, read_short;

    assign in_acc  = i_valid && !o_stall;
    assign fin_go  = !r_out_valid || !i_stall;
    assign mem_we  = (r_state == ST_FIN) && fin_go && !r_ovf;

    // symbol mod SYMBOLS by restoring subtraction
    always_comb begin
        mod_r = 17'(i_symbol);
        for (int k = 7; k >= 0; k--) begin
            if (mod_r >= (17'(SYMBOLS) << k)) begin
                mod_r = mod_r - (17'(SYMBOLS) << k);
            end
        end
        in_idx = mod_r[IW-1:0];
    end

    assign f_cur = r_valid[r_idx] ? r_rd : '0;
    assign sum_n = {1'b0, r_total} + (CW+1)'(r_w);
    assign read_short = sum_n[CW] || (r_total == '0);

    always_comb begin
        unique case (r_lsel)
            2'd0:    log_x = r_total;
            2'd1:    log_x = r_n;
            2'd2:    log_x = r_f;
            default: log_x = r_fw;
        endcase
    end

    // normalize: binary search for the leading one
    assign sh       = NSW'(1) << (SW'(NSTEPS - 1) - r_step);
    assign hi_mask  = ~({XW{1'b1}} >> sh);
    assign top_zero = (r_x & hi_mask) == '0;
    assign x_sh     = top_zero ? (r_x << sh) : r_x;

    // shared multiplier
    assign lc_x   = HW'(r_lc);
    assign last_x = HW'(r_last);
    assign d_x    = (lc_x > last_x) ? (lc_x - last_x) : '0;

    always_comb begin
        unique case (r_term)
            2'd0:    begin mac_log = d_x[LW-1:0]; mac_cnt = r_total; end
            2'd1:    begin mac_log = r_lfw;       mac_cnt = r_fw;    end
            default: begin mac_log = r_lf;        mac_cnt = r_f;     end
        endcase
    end

    assign cnt_pad = (CHUNKS*CHUNK_W)'(mac_cnt);
    assign chunk   = cnt_pad[r_chunk*CHUNK_W +: CHUNK_W];

    always_comb begin
        if (r_state == ST_LOG_SQ) begin
            mul_a = {1'b0, r_m};
            mul_b = {1'b0, r_m};
        end else begin
            mul_a = MUL_W'(mac_log);
            mul_b = MUL_W'(chunk);
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign sq_t     = mul_p[MANT_FRAC +: MUL_W];
    assign mac_term = AW'(mul_p) << {r_chunk, 4'b0000};

    // divider step
    assign acc_hi = r_acc[AW-1:QW];
    assign rem2   = {r_rem, r_q[QW-1]};
    assign q_bit  = rem2 >= {1'b0, r_n};

    assign norm_last = r_step == SW'(NSTEPS - 1);
    assign sq_last   = r_step == SW'(FRAC_BITS - 1);
    assign div_last  = r_step == SW'(QW - 1);
    assign mul_last  = (r_term == 2'd2) && (r_chunk == CKW'(CHUNKS - 1));
    assign div_skip  = acc_hi >= r_n;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_READ;
            ST_READ:     n_state = read_short ? ST_FIN : ST_LOG_LOAD;
            ST_LOG_LOAD: n_state = ST_LOG_NORM;
            ST_LOG_NORM: if (norm_last) n_state = ST_LOG_SQ;
            ST_LOG_SQ: begin
                if (sq_last) n_state = (r_lsel == 2'd3) ? ST_MUL : ST_LOG_LOAD;
            end
            ST_MUL:      if (mul_last) n_state = ST_DIV_CHK;
            ST_DIV_CHK:  n_state = div_skip ? ST_FIN : ST_DIV;
            ST_DIV:      if (div_last) n_state = ST_FIN;
            ST_FIN:      if (fin_go) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid     = r_valid;
        n_total     = r_total;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_ent   = r_out_ent;
        n_out_ovf   = r_out_ovf;
        n_idx       = r_idx;
        n_w         = r_w;
        n_f         = r_f;
        n_n         = r_n;
        n_fw        = r_fw;
        n_ovf       = r_ovf;
        n_h         = r_h;
        n_lsel      = r_lsel;
        n_step      = r_step;
        n_x         = r_x;
        n_xzero     = r_xzero;
        n_exp       = r_exp;
        n_m         = r_m;
        n_frac      = r_frac;
        n_lc        = r_lc;
        n_ln        = r_ln;
        n_lf        = r_lf;
        n_lfw       = r_lfw;
        n_term      = r_term;
        n_chunk     = r_chunk;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_q         = r_q;
        log_val     = '0;
        h_raw       = '0;
        h_x         = '0;

        if (r_out_valid && !i_stall) n_out_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_idx = in_idx;
                    n_w   = i_weight;
                    if (i_new_set) begin
                        n_valid = '0;
                        n_total = '0;
                        n_last  = '0;
                    end
                end
            end
            ST_READ: begin
                n_f    = f_cur;
                n_n    = sum_n[CW-1:0];
                n_fw   = f_cur + CW'(r_w);
                n_ovf  = sum_n[CW];
                n_h    = sum_n[CW] ? r_last : '0;
                n_lsel = 2'd0;
            end
            ST_LOG_LOAD: begin
                n_x     = XW'(log_x);
                n_xzero = log_x == '0;
                n_exp   = EW'(XW - 1);
                n_step  = '0;
            end
            ST_LOG_NORM: begin
                n_x = x_sh;
                if (top_zero) n_exp = r_exp - EW'(sh);
                if (norm_last) begin
                    n_m    = x_sh[XW-1 -: MANT_W];
                    n_step = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_LOG_SQ: begin
                n_m    = sq_t[MUL_W-1] ? sq_t[MUL_W-1:1] : sq_t[MANT_W-1:0];
                n_frac = {r_frac[FRAC_BITS-2:0], sq_t[MUL_W-1]};
                n_step = r_step + 1'b1;
                if (sq_last) begin
                    log_val = r_xzero ? '0 : {r_exp, n_frac};
                    unique case (r_lsel)
                        2'd0:    n_lc  = log_val;
                        2'd1:    n_ln  = log_val;
                        2'd2:    n_lf  = log_val;
                        default: n_lfw = log_val;
                    endcase
                    n_lsel  = r_lsel + 1'b1;
                    n_term  = 2'd0;
                    n_chunk = '0;
                    n_acc   = '0;
                end
            end
            ST_MUL: begin
                // the f*log2(f) term comes off the sum
                n_acc = (r_term == 2'd2) ? (r_acc - mac_term) : (r_acc + mac_term);
                if (r_chunk == CKW'(CHUNKS - 1)) begin
                    n_chunk = '0;
                    n_term  = r_term + 1'b1;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_DIV_CHK: begin
                n_h    = '0;
                n_rem  = acc_hi;
                n_q    = r_acc[QW-1:0];
                n_step = '0;
            end
            ST_DIV: begin
                n_rem  = q_bit ? CW'(rem2 - {1'b0, r_n}) : rem2[CW-1:0];
                n_q    = {r_q[QW-2:0], q_bit};
                n_step = r_step + 1'b1;
                if (div_last) begin
                    h_raw = (n_q >= {1'b0, r_ln}) ? '0 : (r_ln - n_q[LW-1:0]);
                    h_x   = HW'(h_raw);
                    if (h_x > HW'(LIM)) h_x = HW'(LIM);
                    n_h = h_x[ENT_W-1:0];
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_out_valid = 1'b1;
                    n_out_ent   = r_h;
                    n_out_ovf   = r_ovf;
                    if (!r_ovf) begin
                        n_valid[r_idx] = 1'b1;
                        n_total        = r_n;
                        n_last         = r_h;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_total     <= n_total;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ent <= n_out_ent;
        r_out_ovf <= n_out_ovf;
        r_idx     <= n_idx;
        r_w       <= n_w;
        r_f       <= n_f;
        r_n       <= n_n;
        r_fw      <= n_fw;
        r_ovf     <= n_ovf;
        r_h       <= n_h;
        r_lsel    <= n_lsel;
        r_step    <= n_step;
        r_x       <= n_x;
        r_xzero   <= n_xzero;
        r_exp     <= n_exp;
        r_m       <= n_m;
        r_frac    <= n_frac;
        r_lc      <= n_lc;
        r_ln      <= n_ln;
        r_lf      <= n_lf;
        r_lfw     <= n_lfw;
        r_term    <= n_term;
        r_chunk   <= n_chunk;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_q       <= n_q;
    end

    // symbol count memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= r_fw;
        end
        if (in_acc) begin
            r_rd <= mem[in_idx];
        end
    end

    assign o_stall    = r_state != ST_IDLE;
    assign o_valid    = r_out_valid;
    assign o_entropy  = r_out_ent;
    assign o_overflow = r_out_ovf;

    a_new_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_new_set |=> (r_total == '0) && (r_valid == '0))
        else $error("new set did not clear totals");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_READ)
        else $error("accepted word did not start a read");

    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_n)
        else $error("divider remainder out of range");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && fin_go |=> o_valid && (o_entropy == $past(r_h)))
        else $error("result not loaded into output register");

endmodule
